/* sv/dary_max_heap_queue_macros.svh */
// Assertion macros used by the heap queue sequencer.
// Expects signals named clk and arst_n in the including module.
`ifndef DARY_MAX_HEAP_QUEUE_MACROS_SVH
`define DARY_MAX_HEAP_QUEUE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DMHQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define DMHQ_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* sv/dmhq_pkg.sv */
// Package for the d-ary max-heap queue: sizes, codes, types and helper functions.
// No dependencies; every other file of the block but the macro header uses it by scoped names.
`timescale 1ns / 1ps

package dmhq_pkg;

	localparam int CAPACITY = 64;
	localparam int ARITY    = 5;

	localparam int KEY_W  = 32;
	localparam int INC_W  = 31;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 7;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W = $clog2(ARITY * CAPACITY + 1);

	// Reciprocal for the parent index: exact for all indexes below 2**IDX_W
	// because ARITY never exceeds eight.
	localparam int DIV_SHIFT = IDX_W + 3;
	localparam int DIV_RECIP = (2 ** DIV_SHIFT + ARITY - 1) / ARITY;
	localparam int PROD_W    = IDX_W + DIV_SHIFT;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INCREASE = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXT_ROOT,
		ST_EXT_LAST,
		ST_DOWN,
		ST_UP,
		ST_SEARCH,
		ST_FLUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] data;
	} wr_t;

	function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] idx);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(idx - 1'b1) * PROD_W'(DIV_RECIP);
		return prod[DIV_SHIFT +: IDX_W];
	endfunction

	// Signed key plus unsigned increment, saturating at the largest positive key.
	function automatic logic [KEY_W-1:0] sat_add(input logic [KEY_W-1:0] key,
		input logic [INC_W-1:0] inc);
		logic [KEY_W:0] sum;
		sum = {key[KEY_W-1], key} + {{(KEY_W + 1 - INC_W){1'b0}}, inc};
		if (!sum[KEY_W] && sum[KEY_W-1]) begin
			return {1'b0, {(KEY_W - 1){1'b1}}};
		end
		return sum[KEY_W-1:0];
	endfunction

endpackage

/* sv/dmhq_if.sv */
// Valid/ready channel interfaces for heap queue requests and results.
// Depends on dmhq_pkg for the field widths.
`timescale 1ns / 1ps

interface dmhq_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [dmhq_pkg::CMD_W-1:0]        command;
	logic signed [dmhq_pkg::KEY_W-1:0] key_value;
	logic [dmhq_pkg::INC_W-1:0]        increment;

	modport source (output valid, command, key_value, increment, input ready);
	modport sink (input valid, command, key_value, increment, output ready);
endinterface

interface dmhq_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [dmhq_pkg::KEY_W-1:0] result_key;
	logic [dmhq_pkg::STAT_W-1:0]       status;
	logic [dmhq_pkg::OCC_W-1:0]        occupancy;

	modport source (output valid, result_key, status, occupancy, input ready);
	modport sink (input valid, result_key, status, occupancy, output ready);
endinterface

/* sv/dary_max_heap_queue.sv */
// 5-ary max-heap priority queue of signed 32-bit keys, up to 64 entries. The entries
// live in a ring of 64 cells that rotates by one place every clock cycle; the sequencer
// reads and writes only the entry passing the head, so each heap access waits for its
// entry to come round. An extract fetches the root and then the last entry; an increase
// search waits for the root and then scans the entries. At each level a key moves up or
// down, the next level waits until the previous write has landed. One request is worked
// at a time; a new request is taken while the previous result still waits in the output
// register. Full, empty and unused-code requests go straight to the result stage.
//
// Top level of the heap queue: ring of storage cells plus the sequencer.
// Depends on dmhq_pkg, dmhq_if, dmhq_cell and dmhq_ctrl.
`timescale 1ns / 1ps

module dary_max_heap_queue (
	input  logic       clk,
	input  logic       arst_n,
	dmhq_cmd_if.sink   cmd,
	dmhq_res_if.source res
);

	logic [dmhq_pkg::KEY_W-1:0] cell_val [dmhq_pkg::CAPACITY];
	dmhq_pkg::wr_t              ring_wr;

	// Cell k takes the key of cell k+1; the last cell closes the ring from cell 0
	// and is where the sequencer writes the entry now at the head.
	for (genvar k = 0; k < dmhq_pkg::CAPACITY; k++) begin : g_cell
		if (k == dmhq_pkg::CAPACITY - 1) begin : g_tail
			dmhq_cell u_cell (
				.clk      (clk),
				.shift_in (cell_val[0]),
				.wr       (ring_wr),
				.value    (cell_val[k])
			);
		end else begin : g_body
			dmhq_cell u_cell (
				.clk      (clk),
				.shift_in (cell_val[k + 1]),
				.wr       ('0),
				.value    (cell_val[k])
			);
		end
	end

	dmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.head_val (cell_val[0]),
		.wr       (ring_wr)
	);

endmodule

/* sv/dmhq_cell.sv */
// One storage cell of the rotating heap ring: holds one key and passes it on.
// Depends on dmhq_pkg for the key width and the write struct.
`timescale 1ns / 1ps

module dmhq_cell (
	input  logic                       clk,
	input  logic [dmhq_pkg::KEY_W-1:0] shift_in,
	input  dmhq_pkg::wr_t              wr,
	output logic [dmhq_pkg::KEY_W-1:0] value
);

	logic [dmhq_pkg::KEY_W-1:0] value_q;

	// A write replaces the key that is moving into this cell.
	always_ff @(posedge clk) begin
		value_q <= wr.en ? wr.data : shift_in;
	end

	assign value = value_q;

endmodule

/* sv/dmhq_ctrl.sv */
// Sequencer of the heap queue: watches the head of the rotating ring and runs
// insert, extract and increase. Depends on dmhq_pkg, dmhq_if and the macro header.
`timescale 1ns / 1ps
`include "dary_max_heap_queue_macros.svh"

module dmhq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	dmhq_cmd_if.sink                   cmd,
	dmhq_res_if.source                 res,
	input  logic [dmhq_pkg::KEY_W-1:0] head_val,
	output dmhq_pkg::wr_t              wr
);

	localparam int KEY_W   = dmhq_pkg::KEY_W;
	localparam int IDX_W   = dmhq_pkg::IDX_W;
	localparam int CNT_W   = dmhq_pkg::CNT_W;
	localparam int CHILD_W = dmhq_pkg::CHILD_W;

	dmhq_pkg::state_t state_q, state_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic [IDX_W-1:0]  head_q, head_n;
	logic [IDX_W-1:0]  cur_q, cur_n;
	logic [KEY_W-1:0]  val_q, val_n;
	logic [KEY_W-1:0]  best_q, best_n;
	logic [IDX_W-1:0]  bidx_q, bidx_n;
	logic              scan_q, scan_n;
	logic              pend_q, pend_n;
	logic [IDX_W-1:0]  pidx_q, pidx_n;
	logic [KEY_W-1:0]  pval_q, pval_n;
	logic [KEY_W-1:0]  key_q, key_n;
	logic [dmhq_pkg::INC_W-1:0]  inc_q, inc_n;
	logic [KEY_W-1:0]  rkey_q, rkey_n;
	logic [dmhq_pkg::STAT_W-1:0] stat_q, stat_n;
	logic              ov_q, ov_n;
	logic [KEY_W-1:0]  okey_q, okey_n;
	logic [dmhq_pkg::STAT_W-1:0] ostat_q, ostat_n;
	logic [dmhq_pkg::OCC_W-1:0]  occ_q, occ_n;

	logic [CHILD_W-1:0] first_child;
	logic [CHILD_W-1:0] head_w;
	logic [CHILD_W-1:0] cnt_w;
	logic [IDX_W-1:0]   parent;
	logic               child_gt;
	logic               last_child;
	logic [KEY_W-1:0]   nb_val;
	logic [IDX_W-1:0]   nb_idx;
	logic [KEY_W-1:0]   inc_sum;
	logic               direct_wr;

	assign head_w      = CHILD_W'(head_q);
	assign cnt_w       = CHILD_W'(cnt_q);
	assign first_child = CHILD_W'(dmhq_pkg::ARITY) * CHILD_W'(cur_q) + 1'b1;
	assign parent      = dmhq_pkg::parent_of(cur_q);
	assign child_gt    = $signed(head_val) > $signed(best_q);
	assign last_child  = (head_w == first_child + CHILD_W'(dmhq_pkg::ARITY - 1))
		|| (head_w + 1'b1 >= cnt_w);
	assign nb_val      = child_gt ? head_val : best_q;
	assign nb_idx      = child_gt ? head_q : bidx_q;
	assign inc_sum     = dmhq_pkg::sat_add(head_val, inc_q);

	assign head_n = (head_q == IDX_W'(dmhq_pkg::CAPACITY - 1)) ? '0 : head_q + 1'b1;

	assign res.valid      = ov_q;
	assign res.result_key = okey_q;
	assign res.status     = ostat_q;
	assign res.occupancy  = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmhq_pkg::ST_IDLE;
			cnt_q   <= '0;
			head_q  <= '0;
			scan_q  <= 1'b0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			head_q  <= head_n;
			scan_q  <= scan_n;
			pend_q  <= pend_n;
			ov_q    <= ov_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q   <= cur_n;
		val_q   <= val_n;
		best_q  <= best_n;
		bidx_q  <= bidx_n;
		pidx_q  <= pidx_n;
		pval_q  <= pval_n;
		key_q   <= key_n;
		inc_q   <= inc_n;
		rkey_q  <= rkey_n;
		stat_q  <= stat_n;
		okey_q  <= okey_n;
		ostat_q <= ostat_n;
		occ_q   <= occ_n;
	end

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		cur_n     = cur_q;
		val_n     = val_q;
		best_n    = best_q;
		bidx_n    = bidx_q;
		scan_n    = scan_q;
		pend_n    = pend_q;
		pidx_n    = pidx_q;
		pval_n    = pval_q;
		key_n     = key_q;
		inc_n     = inc_q;
		rkey_n    = rkey_q;
		stat_n    = stat_q;
		ov_n      = ov_q;
		okey_n    = okey_q;
		ostat_n   = ostat_q;
		occ_n     = occ_q;
		wr        = '0;
		direct_wr = 1'b0;
		cmd.ready = (state_q == dmhq_pkg::ST_IDLE);

		// A deferred write lands when its entry passes the head.
		if (pend_q && head_q == pidx_q) begin
			wr.en   = 1'b1;
			wr.data = pval_q;
			pend_n  = 1'b0;
		end

		if (ov_q && res.ready) begin
			ov_n = 1'b0;
		end

		unique case (state_q)
			dmhq_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					key_n  = cmd.key_value;
					inc_n  = cmd.increment;
					rkey_n = '0;
					stat_n = dmhq_pkg::STATUS_OK;
					unique case (cmd.command)
						dmhq_pkg::CMD_INSERT: begin
							if (cnt_q == CNT_W'(dmhq_pkg::CAPACITY)) begin
								stat_n  = dmhq_pkg::STATUS_FULL;
								state_n = dmhq_pkg::ST_DONE;
							end else begin
								cnt_n   = cnt_q + 1'b1;
								cur_n   = cnt_q[IDX_W-1:0];
								val_n   = cmd.key_value;
								pend_n  = 1'b1;
								pidx_n  = cnt_q[IDX_W-1:0];
								pval_n  = cmd.key_value;
								state_n = dmhq_pkg::ST_UP;
							end
						end
						dmhq_pkg::CMD_EXTRACT: begin
							if (cnt_q == '0) begin
								stat_n  = dmhq_pkg::STATUS_EMPTY;
								state_n = dmhq_pkg::ST_DONE;
							end else begin
								cnt_n   = cnt_q - 1'b1;
								state_n = dmhq_pkg::ST_EXT_ROOT;
							end
						end
						dmhq_pkg::CMD_INCREASE: begin
							scan_n  = 1'b0;
							state_n = dmhq_pkg::ST_SEARCH;
						end
						default: begin
							state_n = dmhq_pkg::ST_DONE;
						end
					endcase
				end
			end
			dmhq_pkg::ST_EXT_ROOT: begin
				if (head_q == '0) begin
					rkey_n  = head_val;
					state_n = (cnt_q == '0) ? dmhq_pkg::ST_FLUSH : dmhq_pkg::ST_EXT_LAST;
				end
			end
			dmhq_pkg::ST_EXT_LAST: begin
				// The last entry becomes the value that sifts down from the root.
				if (head_q == cnt_q[IDX_W-1:0]) begin
					val_n   = head_val;
					cur_n   = '0;
					best_n  = head_val;
					bidx_n  = '0;
					scan_n  = 1'b0;
					state_n = dmhq_pkg::ST_DOWN;
				end
			end
			dmhq_pkg::ST_DOWN: begin
				if (!scan_q && !pend_q && first_child >= cnt_w) begin
					pend_n  = 1'b1;
					pidx_n  = cur_q;
					pval_n  = val_q;
					state_n = dmhq_pkg::ST_FLUSH;
				end else if (scan_q || (!pend_q && head_w == first_child)) begin
					// Children are consecutive, so they pass the head one per cycle.
					scan_n = 1'b1;
					best_n = nb_val;
					bidx_n = nb_idx;
					if (last_child) begin
						scan_n = 1'b0;
						pend_n = 1'b1;
						pidx_n = cur_q;
						if (nb_idx == cur_q) begin
							pval_n  = val_q;
							state_n = dmhq_pkg::ST_FLUSH;
						end else begin
							pval_n = nb_val;
							cur_n  = nb_idx;
							best_n = val_q;
							bidx_n = nb_idx;
						end
					end
				end
			end
			dmhq_pkg::ST_UP: begin
				if (cur_q == '0) begin
					state_n = dmhq_pkg::ST_FLUSH;
				end else if (head_q == parent && (!pend_q || pidx_q == cur_q)) begin
					if ($signed(val_q) > $signed(head_val)) begin
						// Moving key takes the parent slot now; the parent moves down later.
						wr.en     = 1'b1;
						wr.data   = val_q;
						direct_wr = 1'b1;
						pend_n    = 1'b1;
						pidx_n    = cur_q;
						pval_n    = head_val;
						cur_n     = parent;
					end else begin
						state_n = dmhq_pkg::ST_FLUSH;
					end
				end
			end
			dmhq_pkg::ST_SEARCH: begin
				if (scan_q || head_q == '0) begin
					if (head_w >= cnt_w) begin
						scan_n  = 1'b0;
						stat_n  = dmhq_pkg::STATUS_NOTFOUND;
						state_n = dmhq_pkg::ST_DONE;
					end else if (head_val == key_q) begin
						wr.en     = 1'b1;
						wr.data   = inc_sum;
						direct_wr = 1'b1;
						rkey_n    = inc_sum;
						cur_n     = head_q;
						val_n     = inc_sum;
						scan_n    = 1'b0;
						state_n   = dmhq_pkg::ST_UP;
					end else if (head_q == IDX_W'(dmhq_pkg::CAPACITY - 1)) begin
						scan_n  = 1'b0;
						stat_n  = dmhq_pkg::STATUS_NOTFOUND;
						state_n = dmhq_pkg::ST_DONE;
					end else begin
						scan_n = 1'b1;
					end
				end
			end
			dmhq_pkg::ST_FLUSH: begin
				if (!pend_q) begin
					state_n = dmhq_pkg::ST_DONE;
				end
			end
			dmhq_pkg::ST_DONE: begin
				if (!ov_q || res.ready) begin
					ov_n    = 1'b1;
					okey_n  = rkey_q;
					ostat_n = stat_q;
					occ_n   = dmhq_pkg::OCC_W'(cnt_q);
					state_n = dmhq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = dmhq_pkg::ST_IDLE;
			end
		endcase
	end

	`DMHQ_NEVER(a_wr_clash, direct_wr && pend_q && head_q == pidx_q, "deferred write collides with a direct write")
	`DMHQ_ASSERT(a_cnt_range, cnt_q <= CNT_W'(dmhq_pkg::CAPACITY), "entry count above capacity")
	`DMHQ_NEVER(a_idle_pend, state_q == dmhq_pkg::ST_IDLE && pend_q, "deferred write left behind at idle")
	`DMHQ_ASSERT(a_scan_clean, scan_q && state_q == dmhq_pkg::ST_DOWN |-> !pend_q, "child scan with a deferred write outstanding")
	`DMHQ_ASSERT(a_done_loads, state_q == dmhq_pkg::ST_DONE && (!ov_q || res.ready) |=> ov_q && state_q == dmhq_pkg::ST_IDLE, "finished request not loaded into the result register")

endmodule
